[design/tilemap_blit_address_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tile map blit address generator
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_BLIT_ADDRESS_GENERATOR_ASSERT_SVH
`define TILEMAP_BLIT_ADDRESS_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TMBAG_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmbag same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define TMBAG_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmbag next-cycle check failed");
`else
`define TMBAG_ASSERT_IMP(name, clk, rst, ante, cons)
`define TMBAG_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

[design/tmbag_pkg.sv]
// ----------------------------------------------------------------------------
// Tile map blit address generator package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package tmbag_pkg;

  localparam int DEF_MAX_MAP_WIDTH  = 64;
  localparam int DEF_MAX_MAP_HEIGHT = 64;
  localparam int DEF_TILE_ID_BITS   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int MAP_DIM_W  = 7;
  localparam int PIX_DIM_W  = 9;
  // Map coordinates and clamped window values are held in 9 bits, 0..511.
  localparam int DIM_W      = 9;
  localparam int ROW_LIMIT  = 64;
  localparam int ROW_CNT_W  = 7;

  localparam logic [6:0] RST_MAP_WIDTH   = 7'd64;
  localparam logic [6:0] RST_MAP_HEIGHT  = 7'd64;
  localparam logic [8:0] RST_TILE_WIDTH  = 9'd16;
  localparam logic [8:0] RST_TILE_HEIGHT = 9'd16;
  localparam logic [8:0] RST_TS_COLUMNS  = 9'd16;

  localparam logic [63:0] SRC_X_MAX  = 64'hFFFF;
  localparam logic [63:0] SRC_Y_MAX  = 64'hFF_FFFF;
  localparam logic [63:0] DEST_MAX   = 64'h3FFF;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_TILE_WIDTH  = 3'd2,
    REG_TILE_HEIGHT = 3'd3,
    REG_TS_COLUMNS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               req_type;
    logic [11:0]        cell_address;
    logic [15:0]        tile_value;
    logic signed [15:0] win_x;
    logic signed [15:0] win_y;
    logic signed [15:0] win_w;
    logic signed [15:0] win_h;
    logic [5:0]         row_offset;
  } in_t;

  typedef struct packed {
    logic [15:0] src_x;
    logic [23:0] src_y;
    logic [13:0] dest_x;
    logic [13:0] dest_y;
    logic        last;
  } out_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/tilemap_blit_address_generator.sv]
// ----------------------------------------------------------------------------
// Tile map blit address generator
// Holds a tile map, clamps a view window to it and walks one window row,
// giving a tileset source and destination pixel position per non-empty tile.
// ----------------------------------------------------------------------------
// Map writes are taken while idle and may follow back to back. A render clamps the
// window, forms the row base and reads each cell; a non-empty cell also uses the
// bit-serial divider and the one shared multiplier. A finish state flags the last
// result; output stalls hold a render. A row offset past the window returns to idle
// after the clamp states. Input is stalled during a render. Reset loads register
// defaults; the tile store is not cleared and holds unknown data until written.
module tilemap_blit_address_generator #(
  parameter int MAX_MAP_WIDTH  = tmbag_pkg::DEF_MAX_MAP_WIDTH,
  parameter int MAX_MAP_HEIGHT = tmbag_pkg::DEF_MAX_MAP_HEIGHT,
  parameter int TILE_ID_BITS   = tmbag_pkg::DEF_TILE_ID_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tmbag_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tmbag_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [tmbag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmbag_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "tilemap_blit_address_generator_assert.svh"

  localparam int DEPTH  = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = tmbag_pkg::DIM_W;
  localparam int MA_W   = (TILE_ID_BITS > DW) ? TILE_ID_BITS : DW;
  localparam int PW     = MA_W + tmbag_pkg::PIX_DIM_W;
  localparam int RB_W   = 2 * DW;
  localparam logic [DW-1:0] MAXW = DW'(MAX_MAP_WIDTH);
  localparam logic [DW-1:0] MAXH = DW'(MAX_MAP_HEIGHT);

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP_XY, S_CLAMP_WH, S_ROW_MUL, S_ROW_SET, S_READ, S_FETCH,
    S_DIV, S_MUL_SY, S_MUL_DX, S_MUL_DY, S_MUL_DONE, S_PUSH, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [tmbag_pkg::MAP_DIM_W-1:0] map_width, map_height;
  logic [tmbag_pkg::PIX_DIM_W-1:0] tile_width, tile_height, tileset_columns;

  // Item registers
  tmbag_pkg::in_t                  req;
  logic [DW-1:0]                   win_x0, win_y0, ty, tx;
  logic [tmbag_pkg::ROW_CNT_W-1:0] cnt;
  logic [RB_W-1:0]                 row_base;
  logic [PW-1:0]                   prod;
  tmbag_pkg::out_t                 calc, pend;
  logic                            pend_valid;

  // Combinational
  logic [DW-1:0]            dim_w, dim_h, cx, cy, lim_w, lim_h, cw, ch;
  logic [MA_W-1:0]          mul_a;
  logic [tmbag_pkg::PIX_DIM_W-1:0] mul_b, cols_eff;
  logic [PW-1:0]            prod_next;
  logic [63:0]              prod_wide;
  logic [15:0]              sat_sx;
  logic [23:0]              sat_sy;
  logic [13:0]              sat_dst;
  logic                     out_free, in_fire, ram_we;
  logic [RB_W:0]            cell_sum;
  logic [ADDR_W-1:0]        ram_raddr, ram_waddr;
  logic [TILE_ID_BITS-1:0]  ram_rdata, ram_wdata;
  tmbag_pkg::div_ctl_t      div_ctl;
  tmbag_pkg::div_stat_t     div_stat;
  logic [TILE_ID_BITS-1:0]  div_quo;
  logic [tmbag_pkg::PIX_DIM_W-1:0] div_rem;

  function automatic logic [DW-1:0] clamp_s(input logic signed [15:0] v,
                                             input logic [DW-1:0] hi);
    logic signed [17:0] vs;
    logic signed [17:0] hs;
    vs = 18'(v);
    hs = $signed({{(18 - DW){1'b0}}, hi});
    if (vs > hs) begin
      clamp_s = hi;
    end else if (vs < 18'sd0) begin
      clamp_s = '0;
    end else begin
      clamp_s = vs[DW-1:0];
    end
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign dim_w    = ({2'b0, map_width} > MAXW) ? MAXW : {2'b0, map_width};
  assign dim_h    = ({2'b0, map_height} > MAXH) ? MAXH : {2'b0, map_height};
  assign cols_eff = (tileset_columns == '0) ? tmbag_pkg::PIX_DIM_W'(1) : tileset_columns;

  assign cx    = clamp_s(req.win_x, dim_w);
  assign cy    = clamp_s(req.win_y, dim_h);
  assign lim_w = dim_w - win_x0;
  assign lim_h = dim_h - win_y0;
  assign cw    = clamp_s(req.win_w, lim_w);
  assign ch    = clamp_s(req.win_h, lim_h);

  // Map writes go straight into the store; addresses past its end are dropped.
  assign ram_we    = in_fire && (in_data.req_type == tmbag_pkg::REQ_WRITE)
                     && ({5'b0, in_data.cell_address} < 17'(DEPTH));
  assign ram_waddr = ADDR_W'(in_data.cell_address);
  assign ram_wdata = TILE_ID_BITS'(in_data.tile_value);
  assign cell_sum  = {1'b0, row_base} + (RB_W + 1)'(tx);
  assign ram_raddr = cell_sum[ADDR_W-1:0];

  tmbag_ram #(.WIDTH(TILE_ID_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign div_ctl.start = (state == S_FETCH) && (ram_rdata != '0);

  tmbag_div #(.ID_W(TILE_ID_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (ram_rdata - 1'b1),
    .divisor  (cols_eff),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // The single multiplier serves the row base and all four pixel positions.
  always_comb begin
    case (state)
      S_ROW_MUL: begin
        mul_a = MA_W'(ty);
        mul_b = dim_w;
      end
      S_DIV: begin
        mul_a = MA_W'(div_rem);
        mul_b = tile_width;
      end
      S_MUL_SY: begin
        mul_a = MA_W'(div_quo);
        mul_b = tile_height;
      end
      S_MUL_DX: begin
        mul_a = MA_W'(tx);
        mul_b = tile_width;
      end
      default: begin
        mul_a = MA_W'(ty);
        mul_b = tile_height;
      end
    endcase
    prod_next = PW'(mul_a) * PW'(mul_b);
  end

  assign prod_wide = 64'(prod);
  assign sat_sx  = (prod_wide > tmbag_pkg::SRC_X_MAX) ? 16'hFFFF : prod_wide[15:0];
  assign sat_sy  = (prod_wide > tmbag_pkg::SRC_Y_MAX) ? 24'hFF_FFFF : prod_wide[23:0];
  assign sat_dst = (prod_wide > tmbag_pkg::DEST_MAX) ? 14'h3FFF : prod_wide[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width       <= tmbag_pkg::RST_MAP_WIDTH;
      map_height      <= tmbag_pkg::RST_MAP_HEIGHT;
      tile_width      <= tmbag_pkg::RST_TILE_WIDTH;
      tile_height     <= tmbag_pkg::RST_TILE_HEIGHT;
      tileset_columns <= tmbag_pkg::RST_TS_COLUMNS;
    end else if (cfg_we) begin
      case (cfg_index)
        tmbag_pkg::REG_MAP_WIDTH:   map_width       <= cfg_data[6:0];
        tmbag_pkg::REG_MAP_HEIGHT:  map_height      <= cfg_data[6:0];
        tmbag_pkg::REG_TILE_WIDTH:  tile_width      <= cfg_data;
        tmbag_pkg::REG_TILE_HEIGHT: tile_height     <= cfg_data;
        tmbag_pkg::REG_TS_COLUMNS:  tileset_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && in_data.req_type == tmbag_pkg::REQ_RENDER) begin
            req   <= in_data;
            state <= S_CLAMP_XY;
          end
        end
        S_CLAMP_XY: begin
          win_x0 <= cx;
          win_y0 <= cy;
          state  <= S_CLAMP_WH;
        end
        S_CLAMP_WH: begin
          tx     <= win_x0;
          ty     <= win_y0 + DW'(req.row_offset);
          cnt    <= (cw > DW'(tmbag_pkg::ROW_LIMIT)) ? tmbag_pkg::ROW_CNT_W'(tmbag_pkg::ROW_LIMIT)
                                                    : cw[tmbag_pkg::ROW_CNT_W-1:0];
          // A row offset past the clamped height renders nothing.
          state  <= (DW'(req.row_offset) >= ch) ? S_IDLE : S_ROW_MUL;
        end
        S_ROW_MUL: begin
          state <= S_ROW_SET;
        end
        S_ROW_SET: begin
          row_base <= prod[RB_W-1:0];
          state    <= (cnt == '0) ? S_FINISH : S_READ;
        end
        S_READ: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (ram_rdata != '0) begin
            state <= S_DIV;
          end else begin
            tx    <= tx + 1'b1;
            cnt   <= cnt - 1'b1;
            state <= (cnt == tmbag_pkg::ROW_CNT_W'(1)) ? S_FINISH : S_READ;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_MUL_SY;
          end
        end
        S_MUL_SY: begin
          calc.src_x <= sat_sx;
          state      <= S_MUL_DX;
        end
        S_MUL_DX: begin
          calc.src_y <= sat_sy;
          state      <= S_MUL_DY;
        end
        S_MUL_DY: begin
          calc.dest_x <= sat_dst;
          state       <= S_MUL_DONE;
        end
        S_MUL_DONE: begin
          calc.dest_y <= sat_dst;
          calc.last   <= 1'b0;
          state       <= S_PUSH;
        end
        S_PUSH: begin
          // One result is held back so the final one of the row can be flagged.
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_data  <= pend;
              out_valid <= 1'b1;
            end
            pend       <= calc;
            pend_valid <= 1'b1;
            tx         <= tx + 1'b1;
            cnt        <= cnt - 1'b1;
            state      <= (cnt == tmbag_pkg::ROW_CNT_W'(1)) ? S_FINISH : S_READ;
          end
        end
        S_FINISH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_data      <= pend;
            out_data.last <= 1'b1;
            out_valid     <= 1'b1;
            pend_valid    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMBAG_ASSERT_IMP(a_idle_no_pending, clk, rst, state == S_IDLE, !pend_valid)
  `TMBAG_ASSERT_IMP(a_row_count_limit, clk, rst, 1'b1,
                    cnt <= tmbag_pkg::ROW_CNT_W'(tmbag_pkg::ROW_LIMIT))
  `TMBAG_ASSERT_IMP(a_div_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `TMBAG_ASSERT_NXT(a_last_flagged, clk, rst,
                    state == S_FINISH && pend_valid && out_free,
                    out_valid && out_data.last)

endmodule

[design/tmbag_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmbag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tmbag_div.sv]
// ----------------------------------------------------------------------------
// Tile id divider
// Restoring divider, one quotient bit per cycle, for the tileset column split.
// ----------------------------------------------------------------------------
module tmbag_div #(
  parameter int ID_W = tmbag_pkg::DEF_TILE_ID_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmbag_pkg::div_ctl_t             ctl,
  input  logic [ID_W-1:0]                 dividend,
  input  logic [tmbag_pkg::PIX_DIM_W-1:0] divisor,
  output tmbag_pkg::div_stat_t            stat,
  output logic [ID_W-1:0]                 quo,
  output logic [tmbag_pkg::PIX_DIM_W-1:0] rem
);

  localparam int CNT_W = $clog2(ID_W + 1);

  logic [CNT_W-1:0]                 cnt;
  logic [tmbag_pkg::PIX_DIM_W-1:0]  dvs;
  logic [tmbag_pkg::PIX_DIM_W:0]    rem_sh;
  logic                             fits;

  // The partial remainder stays below the divisor, so one extra bit suffices.
  assign rem_sh = {rem, quo[ID_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (ctl.start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(ID_W);
        quo       <= dividend;
        rem       <= '0;
        dvs       <= divisor;
      end else if (stat.busy) begin
        quo <= {quo[ID_W-2:0], fits};
        rem <= fits ? tmbag_pkg::PIX_DIM_W'(rem_sh - {1'b0, dvs})
                    : rem_sh[tmbag_pkg::PIX_DIM_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile map blit address generator testbench
// Fills the tile map with cell writes and renders window rows under several
// register settings. Each accepted request is run through a local model of the
// map and the window clamp, and every blit command that leaves the block is
// checked field by field against the oldest predicted one. The sender and the
// receiver idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tmbag_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tmbag_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [tmbag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tmbag_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting for the driver, and blit commands still owed by the block.
  tmbag_pkg::in_t request_queue[$];
  tmbag_pkg::out_t blit_expect[$];

  // Local copy of the map and of the registers, as the block should hold them.
  logic [15:0] tile_map[4096];
  int map_w_reg = 64;
  int map_h_reg = 64;
  int tile_w_reg = 16;
  int tile_h_reg = 16;
  int ts_cols_reg = 16;

  // Cells already written by queued requests; unwritten cells are never rendered.
  bit cell_written[4096];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  int mismatches = 0;
  int blits_checked = 0;
  int writes_done = 0;
  int renders_done = 0;
  int settings_used = 0;

  tilemap_blit_address_generator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic logic [63:0] sat_to(logic [63:0] v, logic [63:0] maxv);
    return (v > maxv) ? maxv : v;
  endfunction

  // Clamp the requested window to the map as it is currently sized.
  function automatic void window_clip(input tmbag_pkg::in_t it, output int mw,
                                      output int mh, output int x0, output int y0,
                                      output int wn, output int hn);
    mw = (map_w_reg > tmbag_pkg::DEF_MAX_MAP_WIDTH) ? tmbag_pkg::DEF_MAX_MAP_WIDTH
                                                     : map_w_reg;
    mh = (map_h_reg > tmbag_pkg::DEF_MAX_MAP_HEIGHT) ? tmbag_pkg::DEF_MAX_MAP_HEIGHT
                                                      : map_h_reg;
    x0 = clamp_to(int'(it.win_x), 0, mw);
    y0 = clamp_to(int'(it.win_y), 0, mh);
    wn = clamp_to(int'(it.win_w), 0, mw - x0);
    hn = clamp_to(int'(it.win_h), 0, mh - y0);
  endfunction

  // Apply one accepted request to the local map and queue the blit commands it owes.
  function automatic void predict_blits(tmbag_pkg::in_t it);
    int mw, mh, x0, y0, wn, hn, ty;
    logic [63:0] id, cols;
    tmbag_pkg::out_t cmd, held;
    bit have_held;
    if (it.req_type == tmbag_pkg::REQ_WRITE) begin
      tile_map[it.cell_address] = it.tile_value;
      writes_done++;
      return;
    end
    renders_done++;
    window_clip(it, mw, mh, x0, y0, wn, hn);
    if (int'(it.row_offset) >= hn) return;
    if (wn > tmbag_pkg::ROW_LIMIT) wn = tmbag_pkg::ROW_LIMIT;
    ty = y0 + int'(it.row_offset);
    cols = (ts_cols_reg == 0) ? 64'd1 : 64'(ts_cols_reg);
    have_held = 1'b0;
    for (int tx = x0; tx < x0 + wn; tx++) begin
      id = 64'(tile_map[tx + ty * mw]);
      if (id == 0) continue;
      id = id - 1;
      cmd.src_x = 16'(sat_to((id % cols) * 64'(tile_w_reg), tmbag_pkg::SRC_X_MAX));
      cmd.src_y = 24'(sat_to((id / cols) * 64'(tile_h_reg), tmbag_pkg::SRC_Y_MAX));
      cmd.dest_x = 14'(sat_to(64'(tx * tile_w_reg), tmbag_pkg::DEST_MAX));
      cmd.dest_y = 14'(sat_to(64'(ty * tile_h_reg), tmbag_pkg::DEST_MAX));
      cmd.last = 1'b0;
      // The previous command is known not to be last once another one follows.
      if (have_held) blit_expect.push_back(held);
      held = cmd;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      blit_expect.push_back(held);
    end
  endfunction

  function automatic tmbag_pkg::in_t random_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    random_item = raw[$bits(tmbag_pkg::in_t)-1:0];
  endfunction

  // Mostly empty cells and small ids, with the odd id from the full range.
  function automatic logic [15:0] random_tile();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return 16'd0;
    if (pick < 80) return 16'($urandom_range(40, 1));
    return 16'($urandom());
  endfunction

  task automatic queue_write(int addr, logic [15:0] value);
    tmbag_pkg::in_t it;
    it = random_item();
    it.req_type = tmbag_pkg::REQ_WRITE;
    it.cell_address = 12'(addr);
    it.tile_value = value;
    cell_written[addr] = 1'b1;
    request_queue.push_back(it);
  endtask

  // Any cell of the rendered row not yet written gets a write queued ahead of it.
  task automatic queue_render(tmbag_pkg::in_t it);
    int mw, mh, x0, y0, wn, hn, cell_idx;
    window_clip(it, mw, mh, x0, y0, wn, hn);
    if (int'(it.row_offset) < hn) begin
      for (int tx = x0; tx < x0 + wn; tx++) begin
        cell_idx = tx + (y0 + int'(it.row_offset)) * mw;
        if (!cell_written[cell_idx]) queue_write(cell_idx, random_tile());
      end
    end
    request_queue.push_back(it);
  endtask

  task automatic direct_render(int x, int y, int w, int h, int off);
    tmbag_pkg::in_t it;
    it = random_item();
    it.req_type = tmbag_pkg::REQ_RENDER;
    it.win_x = 16'(x);
    it.win_y = 16'(y);
    it.win_w = 16'(w);
    it.win_h = 16'(h);
    it.row_offset = 6'(off);
    queue_render(it);
  endtask

  // A window near the map edges with an offset that usually lands inside it.
  function automatic tmbag_pkg::in_t shaped_render();
    tmbag_pkg::in_t it;
    int mw, mh, x0, y0, wn, hn;
    it = random_item();
    it.req_type = tmbag_pkg::REQ_RENDER;
    window_clip(it, mw, mh, x0, y0, wn, hn);
    it.win_x = 16'(int'($urandom_range(mw + 2)) - 1);
    it.win_y = 16'(int'($urandom_range(mh + 2)) - 1);
    it.win_w = 16'(int'($urandom_range(mw + 3)) - 1);
    it.win_h = 16'(int'($urandom_range(mh + 3)) - 1);
    window_clip(it, mw, mh, x0, y0, wn, hn);
    if (hn > 0 && $urandom_range(99) < 85) it.row_offset = 6'($urandom_range(hn - 1));
    return it;
  endfunction

  task automatic write_reg(tmbag_pkg::reg_idx_t idx,
                           logic [tmbag_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tmbag_pkg::REG_MAP_WIDTH: map_w_reg = int'(value[tmbag_pkg::MAP_DIM_W-1:0]);
      tmbag_pkg::REG_MAP_HEIGHT: map_h_reg = int'(value[tmbag_pkg::MAP_DIM_W-1:0]);
      tmbag_pkg::REG_TILE_WIDTH: tile_w_reg = int'(value);
      tmbag_pkg::REG_TILE_HEIGHT: tile_h_reg = int'(value);
      tmbag_pkg::REG_TS_COLUMNS: ts_cols_reg = int'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(int mw, int mh, int tw, int th, int cols);
    write_reg(tmbag_pkg::REG_MAP_WIDTH, 9'(mw));
    write_reg(tmbag_pkg::REG_MAP_HEIGHT, 9'(mh));
    write_reg(tmbag_pkg::REG_TILE_WIDTH, 9'(tw));
    write_reg(tmbag_pkg::REG_TILE_HEIGHT, 9'(th));
    write_reg(tmbag_pkg::REG_TS_COLUMNS, 9'(cols));
    settings_used++;
  endtask

  // Wait until every request is taken and every command is back, then let a
  // render with no commands finish before anything else touches the block.
  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || blit_expect.size() != 0)
      @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic run_phase(int count, int idle, int stall);
    tmbag_pkg::in_t it;
    int pick;
    @(negedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_write($urandom_range(4095), random_tile());
      end else if (pick < 25) begin
        it = random_item();
        it.req_type = tmbag_pkg::REQ_RENDER;
        queue_render(it);
      end else begin
        queue_render(shaped_render());
      end
    end
    wait_idle();
  endtask

  // Driver: a request stays on the bus until a transfer takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_blits(in_data);
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatches++;
  endtask

  // Monitor: every transfer out of the block is matched with the oldest prediction.
  always @(posedge clk) begin : monitor_blk
    tmbag_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blit_expect.size() == 0) begin
        $display("%0t: unexpected blit command, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = blit_expect.pop_front();
        blits_checked++;
        if (out_data.src_x !== want.src_x) flag_field("src_x", want.src_x, out_data.src_x);
        if (out_data.src_y !== want.src_y) flag_field("src_y", want.src_y, out_data.src_y);
        if (out_data.dest_x !== want.dest_x)
          flag_field("dest_x", want.dest_x, out_data.dest_x);
        if (out_data.dest_y !== want.dest_y)
          flag_field("dest_y", want.dest_y, out_data.dest_y);
        if (out_data.last !== want.last) flag_field("last", want.last, out_data.last);
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a 4 x 3 map: row 0 holds the id extremes, row 1 is all
    // empty and row 2 holds a single tile.
    set_config(4, 3, 16, 16, 16);
    @(negedge clk);
    queue_write(0, 16'd1);
    queue_write(1, 16'd0);
    queue_write(2, 16'hFFFF);
    queue_write(3, 16'd17);
    for (int c = 4; c < 8; c++) queue_write(c, 16'd0);
    queue_write(8, 16'd0);
    queue_write(9, 16'd0);
    queue_write(10, 16'd2);
    queue_write(11, 16'd0);
    queue_write(4095, 16'hFFFF);
    direct_render(0, 0, 4, 3, 0);
    direct_render(0, 0, 4, 3, 1);
    direct_render(0, 0, 4, 3, 2);
    direct_render(-32768, -32768, -32768, -32768, 0);
    direct_render(32767, 32767, 32767, 32767, 0);
    direct_render(1, 0, 32767, 32767, 0);
    direct_render(-5, 1, 32767, 32767, 1);
    direct_render(0, 0, 4, 3, 63);
    direct_render(0, 2, 4, 5, 0);
    direct_render(2, 0, -1, 3, 0);
    direct_render(0, 0, 4, 3, 3);
    wait_idle();

    set_config(10, 7, 8, 8, 5);
    run_phase(12, 47, 0);

    // Oversized map sizes saturate; huge tiles saturate the larger pixel positions.
    set_config(127, 127, 511, 511, 1);
    run_phase(3, 0, 47);

    set_config(64, 1, 256, 1, 511);
    run_phase(4, 14, 14);

    // Zero tile sizes and zero tileset columns.
    set_config(5, 4, 0, 0, 0);
    run_phase(8, 14, 14);

    // A map of zero size renders nothing at all.
    set_config(0, 0, 16, 16, 16);
    run_phase(3, 0, 0);

    set_config(1, 1, 256, 256, 256);
    run_phase(5, 47, 47);

    // Full rows while the receiver holds off, so the block backs up to its input.
    set_config(16, 4, 16, 16, 16);
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 8; k++) direct_render(0, 0, 16, 4, k % 4);
    @(posedge clk);
    hold_left <= 400;
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      set_config($urandom_range(12, 1),
                 $urandom_range(12, 1),
                 ($urandom_range(99) < 80) ? $urandom_range(40, 1) : $urandom_range(511),
                 ($urandom_range(99) < 80) ? $urandom_range(40, 1) : $urandom_range(511),
                 ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(511));
      case (k)
        0: run_phase(6, 0, 0);
        1: run_phase(6, 47, 0);
        2: run_phase(6, 0, 47);
        default: run_phase(6, 14, 14);
      endcase
    end

    $display("Checked %0d blit commands from %0d row renders and %0d map writes.",
             blits_checked, renders_done, writes_done);
    $display("Ran %0d register settings, zero and saturated sizes among them, %0d mismatches.",
             settings_used, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
